>>> hw/rtl/multi_led_blink_pattern_controller_top_assert.svh
// assertion macros shared by the blink controller modules
`ifndef MULTI_LED_BLINK_PATTERN_CONTROLLER_TOP_ASSERT_SVH
`define MULTI_LED_BLINK_PATTERN_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MLED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MLED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mled_pkg.sv
// types and constants of the multi-led blink pattern controller
package mled_pkg;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // pattern mode codes (six and seven behave as steady off)
  localparam logic [2:0] MODE_OFF       = 3'd0;
  localparam logic [2:0] MODE_ON        = 3'd1;
  localparam logic [2:0] MODE_SLOW_NUM  = 3'd2;
  localparam logic [2:0] MODE_FAST_NUM  = 3'd3;
  localparam logic [2:0] MODE_SLOW_CONT = 3'd4;
  localparam logic [2:0] MODE_FAST_CONT = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_SLOW_ON  = 2'd0;
  localparam logic [1:0] REG_SLOW_OFF = 2'd1;
  localparam logic [1:0] REG_FAST_ON  = 2'd2;
  localparam logic [1:0] REG_FAST_OFF = 2'd3;

  // register reset values
  localparam logic [7:0] SLOW_ON_RST  = 8'd50;
  localparam logic [7:0] SLOW_OFF_RST = 8'd50;
  localparam logic [7:0] FAST_ON_RST  = 8'd10;
  localparam logic [7:0] FAST_OFF_RST = 8'd10;

  // phase lengths
  typedef struct packed {
    logic [7:0] slow_on;
    logic [7:0] slow_off;
    logic [7:0] fast_on;
    logic [7:0] fast_off;
  } blink_cfg_t;

  // one led's pattern state
  typedef struct packed {
    logic [2:0] mode;
    logic       lit;
    logic       chg;
    logic [7:0] timer;
    logic [7:0] done;
    logic [7:0] wanted;
  } led_state_t;

  // one input word
  typedef struct packed {
    logic       cmd;
    logic [2:0] led_index;
    logic [2:0] pattern_mode;
    logic [7:0] blink_target;
  } item_t;

endpackage

>>> hw/rtl/mled_led_unit.sv
// shared per-led pattern updater: next state of one led for one tick
module mled_led_unit (
  input  mled_pkg::led_state_t cur_st,
  input  mled_pkg::blink_cfg_t cfg,
  output mled_pkg::led_state_t nxt_st
);

  logic numbered;
  logic slow;
  logic blinking;

  // mode decode
  assign numbered = (cur_st.mode == mled_pkg::MODE_SLOW_NUM) ||
                    (cur_st.mode == mled_pkg::MODE_FAST_NUM);
  assign slow     = (cur_st.mode == mled_pkg::MODE_SLOW_NUM) ||
                    (cur_st.mode == mled_pkg::MODE_SLOW_CONT);
  assign blinking = (cur_st.mode == mled_pkg::MODE_SLOW_NUM)  ||
                    (cur_st.mode == mled_pkg::MODE_FAST_NUM)  ||
                    (cur_st.mode == mled_pkg::MODE_SLOW_CONT) ||
                    (cur_st.mode == mled_pkg::MODE_FAST_CONT);

  // phase machine of one led
  always_comb begin
    nxt_st = cur_st;
    if (blinking) begin
      if (!cur_st.lit) begin
        if (cur_st.chg) begin
          nxt_st.chg = 1'b0;
          if (numbered) begin
            nxt_st.done = cur_st.done + 8'd1;
          end
          nxt_st.timer = slow ? cfg.slow_off : cfg.fast_off;
        end else if (cur_st.timer != 8'd0) begin
          nxt_st.timer = cur_st.timer - 8'd1;
        end else begin
          if (numbered && (cur_st.done >= cur_st.wanted)) begin
            nxt_st.mode = mled_pkg::MODE_OFF;
          end else begin
            nxt_st.lit = 1'b1;
          end
          nxt_st.chg = 1'b1;
        end
      end else begin
        if (cur_st.chg) begin
          nxt_st.chg = 1'b0;
          if (numbered && (cur_st.done > cur_st.wanted)) begin
            nxt_st.mode = mled_pkg::MODE_OFF;
          end else begin
            nxt_st.timer = slow ? cfg.slow_on : cfg.fast_on;
          end
        end else if (cur_st.timer != 8'd0) begin
          nxt_st.timer = cur_st.timer - 8'd1;
        end else begin
          nxt_st.lit = 1'b0;
          nxt_st.chg = 1'b1;
        end
      end
    end else begin
      // steady modes clear the counts; unknown codes keep their stored mode
      nxt_st.done   = 8'd0;
      nxt_st.wanted = 8'd0;
      nxt_st.lit    = (cur_st.mode == mled_pkg::MODE_ON);
      nxt_st.chg    = 1'b0;
    end
  end

endmodule

>>> hw/rtl/mled_core.sv
// led state store and sequencer that walks the shared updater over every led
module mled_core #(
  parameter int LED_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mled_pkg::blink_cfg_t cfg,
  input  logic                 start_valid,
  output logic                 start_ready,
  input  mled_pkg::item_t      item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [7:0]           res_pins
);

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  mled_pkg::led_state_t st_r [LED_COUNT];
  mled_pkg::led_state_t cur_st;
  mled_pkg::led_state_t upd_st;
  logic                 accept;
  logic                 set_we;
  logic                 run_we;
  logic                 last_led;

  assign start_ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign accept      = start_valid && start_ready;
  assign set_we      = accept && (item.cmd == mled_pkg::CMD_SET) &&
                       (32'(item.led_index) < LED_COUNT);
  assign run_we      = (state_r == S_RUN);
  assign last_led    = (32'(cnt_r) == 32'(LED_COUNT - 1));

  // shared updater on the led picked by the sequencer
  assign cur_st = st_r[cnt_r];

  mled_led_unit u_unit (
    .cur_st (cur_st),
    .cfg    (cfg),
    .nxt_st (upd_st)
  );

  // pin vector from the first eight leds
  for (genvar b = 0; b < 8; b++) begin : g_pins
    if (b < LED_COUNT) begin : g_led
      assign res_pins[b] = st_r[b].lit;
    end else begin : g_none
      assign res_pins[b] = 1'b0;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = (item.cmd == mled_pkg::CMD_SET) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (last_led) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // per-led state: write-back from the updater or a set command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < LED_COUNT; n++) begin
        st_r[n] <= '0;
      end
    end else begin
      for (int n = 0; n < LED_COUNT; n++) begin
        if (run_we && (32'(cnt_r) == 32'(n))) begin
          st_r[n] <= upd_st;
        end else if (set_we && (32'(item.led_index) == 32'(n))) begin
          st_r[n].mode   <= item.pattern_mode;
          st_r[n].wanted <= item.blink_target;
        end
      end
    end
  end

  `include "multi_led_blink_pattern_controller_top_assert.svh"

  `MLED_ASSERT_NOW(a_cnt_range, state_r == S_RUN, 32'(cnt_r) < LED_COUNT, "led index out of range")
  `MLED_ASSERT_NEXT(a_tick_start, accept && (item.cmd == mled_pkg::CMD_TICK), (state_r == S_RUN) && (cnt_r == '0), "tick did not start at first led")
  `MLED_ASSERT_NEXT(a_set_pins, accept && (item.cmd == mled_pkg::CMD_SET), $stable(res_pins), "set command changed the pins")

endmodule

>>> hw/rtl/multi_led_blink_pattern_controller_top.sv
// top level of the multi-led blink pattern controller
//
//  port group | dir | contents
//  in_*       | in  | command words: tuser = cmd, tdata = index, mode, target
//  out_*      | out | pin vector word after each command
//  cfg_*      | in  | phase length registers, write only
//
// a tick word walks one updater over the leds, visiting one led per cycle,
// then the pins move to the output register. a set word writes its led, then moves the pins there.
// the output register lets the next word in while the last pins wait.
// reset is synchronous: leds and output clear, phase lengths take reset values.
module multi_led_blink_pattern_controller_top #(
  parameter int LED_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // led_index[2:0], pattern_mode[5:3], blink_target[13:6]
  input  logic        in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // led_pins[7:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  mled_pkg::blink_cfg_t cfg_r;
  mled_pkg::item_t      item;
  logic                 res_valid;
  logic                 res_ready;
  logic [7:0]           res_pins;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;

  // unpack the input word
  assign item.cmd          = in_tuser;
  assign item.led_index    = in_tdata[2:0];
  assign item.pattern_mode = in_tdata[5:3];
  assign item.blink_target = in_tdata[13:6];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_on  <= mled_pkg::SLOW_ON_RST;
      cfg_r.slow_off <= mled_pkg::SLOW_OFF_RST;
      cfg_r.fast_on  <= mled_pkg::FAST_ON_RST;
      cfg_r.fast_off <= mled_pkg::FAST_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mled_pkg::REG_SLOW_ON:  cfg_r.slow_on  <= cfg_wdata;
        mled_pkg::REG_SLOW_OFF: cfg_r.slow_off <= cfg_wdata;
        mled_pkg::REG_FAST_ON:  cfg_r.fast_on  <= cfg_wdata;
        mled_pkg::REG_FAST_OFF: cfg_r.fast_off <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mled_core #(
    .LED_COUNT (LED_COUNT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .start_valid (in_tvalid),
    .start_ready (in_tready),
    .item        (item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_pins    (res_pins)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_data_r <= '0;
    end else if (res_valid && res_ready) begin
      out_data_r <= res_pins;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `include "multi_led_blink_pattern_controller_top_assert.svh"

  `MLED_ASSERT_NEXT(a_out_load, res_valid && res_ready, out_valid_r && (out_data_r == $past(res_pins)), "pins not loaded into output register")

endmodule
